@@ hw/rtl/pifr_pkg.sv @@
`timescale 1ns / 1ps

package pifr_pkg;

	localparam int MAX_BYTES_DEF = 32;
	localparam int RESULT_CAP = 32;
	localparam int QDEPTH = 4;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [8:0] BIT_COUNT_MAX = 9'd511;
	localparam logic [15:0] IDLE_RESET = 16'd5000;
	localparam logic [15:0] IDLE_SAT = 16'hFFFF;
	localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [2:0] REG_OWN_ID = 3'd0;
	localparam logic [2:0] REG_EDGE_THRESHOLD = 3'd1;
	localparam logic [2:0] REG_GARBAGE_LIMIT = 3'd2;
	localparam logic [2:0] REG_ZERO_LIMIT = 3'd3;
	localparam logic [2:0] REG_ONE_LIMIT = 3'd4;
	localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd5;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_ADDR = 2'd1,
		ST_LENGTH = 2'd2,
		ST_CRC = 2'd3
	} status_t;

	typedef struct packed {
		logic [5:0] own_id;
		logic [9:0] edge_threshold;
		logic [15:0] garbage_limit;
		logic [15:0] zero_limit;
		logic [15:0] one_limit;
		logic [15:0] idle_timeout;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		own_id: 6'd0,
		edge_threshold: 10'd80,
		garbage_limit: 16'd5,
		zero_limit: 16'd13,
		one_limit: 16'd26,
		idle_timeout: 16'd5000
	};

	// One event per sample at most: a decoded bit, a frame close, or both.
	typedef struct packed {
		logic has_bit;
		logic bit_val;
		logic close;
	} evt_t;

	// One step of the reflected CRC-16, fed one data bit, LSB first.
	function automatic logic [15:0] crc_bit(input logic [15:0] c, input logic b);
		logic fb;
		fb = c[0] ^ b;
		return (c >> 1) ^ (fb ? CRC_POLY : 16'd0);
	endfunction

endpackage

@@ hw/rtl/pifr_ram.sv @@
`timescale 1ns / 1ps

module pifr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pifr_pkg::MAX_BYTES_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/pifr_fifo.sv @@
`timescale 1ns / 1ps

module pifr_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pifr_pkg::evt_t    din,
	input  logic              pop,
	output pifr_pkg::evt_t    dout,
	output logic              full,
	output logic              empty
);

	localparam int PW = $clog2(pifr_pkg::QDEPTH);

	pifr_pkg::evt_t slot_q [pifr_pkg::QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] cnt_q;

	assign full = (cnt_q == (PW+1)'(pifr_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push && !full, pop && !empty})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/pifr_front.sv @@
`timescale 1ns / 1ps

module pifr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  pifr_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [9:0]        sample,
	input  logic              q_full,
	output logic              push,
	output pifr_pkg::evt_t    evt
);

	logic [9:0] prev_q;
	logic [15:0] idle_q;
	logic started_q;

	logic accept;
	logic edge_seen;
	logic [15:0] idle_edge;
	logic [15:0] idle_next;
	logic started_next;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	always_comb begin
		edge_seen = {2'b00, sample} > ({2'b00, prev_q} + {2'b00, cfg.edge_threshold});
		evt = '0;
		if (edge_seen) begin
			if (idle_q < cfg.garbage_limit) begin
				evt.has_bit = 1'b0;
			end else if (idle_q < cfg.zero_limit) begin
				evt.has_bit = 1'b1;
				evt.bit_val = 1'b0;
			end else if (idle_q < cfg.one_limit) begin
				evt.has_bit = 1'b1;
				evt.bit_val = 1'b1;
			end
		end
		idle_edge = edge_seen ? 16'd0 : idle_q;
		idle_next = (idle_edge != pifr_pkg::IDLE_SAT) ? idle_edge + 16'd1 : idle_edge;
		// A frame has started as soon as any bit was counted, preamble included.
		started_next = started_q || evt.has_bit;
		evt.close = (idle_next > cfg.idle_timeout) && started_next;
		push = accept && (evt.has_bit || evt.close);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			idle_q <= pifr_pkg::IDLE_RESET;
			started_q <= 1'b0;
		end else if (accept) begin
			if (evt.close) begin
				prev_q <= '0;
				idle_q <= pifr_pkg::IDLE_RESET;
				started_q <= 1'b0;
			end else begin
				prev_q <= sample;
				idle_q <= idle_next;
				started_q <= started_next;
			end
		end
	end

endmodule

@@ hw/rtl/pifr_back.sv @@
`timescale 1ns / 1ps

module pifr_back #(
	parameter int MAX_BYTES = pifr_pkg::MAX_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pifr_pkg::cfg_t    cfg,
	input  pifr_pkg::evt_t    evt,
	input  logic              q_empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        byte_value,
	output logic [4:0]        byte_index,
	output logic [1:0]        status,
	output logic              broadcast,
	output logic              last
);

	localparam int AW = $clog2(MAX_BYTES);
	localparam int CAP = (MAX_BYTES < pifr_pkg::RESULT_CAP) ? MAX_BYTES : pifr_pkg::RESULT_CAP;

	typedef enum logic [2:0] {
		S_RUN = 3'b001,
		S_CLOSE = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t state_q;

	// Frame under reception.
	logic [8:0] bit_cnt_q;
	logic [7:0] cur_q;
	logic [15:0] crc_q;
	logic [15:0] crc_base_q;
	logic [15:0] crc_excl_q;
	logic [7:0] first_q;
	logic [7:0] third_q;
	logic [7:0] last_byte_q;
	logic ovf_q;

	// Frame being reported.
	logic [5:0] full_e_q;
	logic [5:0] cnt_e_q;
	logic [7:0] part_e_q;
	pifr_pkg::status_t status_e_q;
	logic bc_e_q;
	logic [5:0] k_q;
	logic [5:0] k_rd_q;
	logic rd_pend_q;

	logic out_valid_q;
	logic [7:0] byte_value_q;
	logic [4:0] byte_index_q;
	logic [1:0] status_q;
	logic broadcast_q;
	logic last_q;

	logic past;
	logic [8:0] off;
	logic [5:0] idx;
	logic [2:0] pos;
	logic over;
	logic [7:0] nb;
	logic [15:0] crc_nx;
	logic take;
	logic wr;
	logic [8:0] off5;
	logic [6:0] cnt_raw;
	logic [6:0] cnt_cap;
	logic [5:0] full;
	logic [7:0] byte0;
	pifr_pkg::status_t stat_c;
	logic issue;
	logic [7:0] ram_rdata;

	always_comb begin
		past = bit_cnt_q >= 9'd4;
		off = bit_cnt_q - 9'd4;
		idx = off[8:3];
		pos = off[2:0];
		over = (bit_cnt_q == pifr_pkg::BIT_COUNT_MAX)
			|| (past && ({1'b0, idx} >= 7'(MAX_BYTES)));
		// Bits arrive LSB first, so the byte shifts right and a one lands in bit 7.
		nb = {evt.bit_val, cur_q[7:1]};
		crc_nx = pifr_pkg::crc_bit(crc_q, evt.bit_val);
		pop = (state_q == S_RUN) && !q_empty;
		take = pop && evt.has_bit && !over;
		wr = take && past && (pos == 3'd7);

		off5 = bit_cnt_q - 9'd5;
		cnt_raw = (bit_cnt_q >= 9'd5) ? ({1'b0, off5[8:3]} + 7'd1) : 7'd1;
		cnt_cap = (cnt_raw > 7'(CAP)) ? 7'(CAP) : cnt_raw;
		full = past ? idx : 6'd0;
		byte0 = (full != 6'd0) ? first_q : cur_q;

		if ((byte0 != {2'b00, cfg.own_id}) && (byte0 != pifr_pkg::BROADCAST_ADDR)) begin
			stat_c = pifr_pkg::ST_NOT_ADDR;
		end else if (ovf_q || (full < 6'd3) || ({3'b000, full} != ({1'b0, third_q} + 9'd3))) begin
			stat_c = pifr_pkg::ST_LENGTH;
		end else if (crc_excl_q[7:0] != last_byte_q) begin
			stat_c = pifr_pkg::ST_CRC;
		end else begin
			stat_c = pifr_pkg::ST_OK;
		end

		issue = (state_q == S_EMIT) && !rd_pend_q && (k_q < cnt_e_q)
			&& (!out_valid_q || !out_stall);
	end

	pifr_ram #(
		.WIDTH(8),
		.DEPTH(MAX_BYTES)
	) u_store (
		.clk(clk),
		.we(wr),
		.waddr(idx[AW-1:0]),
		.wdata(nb),
		.re(issue),
		.raddr(k_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			bit_cnt_q <= '0;
			cur_q <= '0;
			crc_q <= pifr_pkg::CRC_INIT;
			crc_base_q <= pifr_pkg::CRC_INIT;
			crc_excl_q <= pifr_pkg::CRC_INIT;
			first_q <= '0;
			third_q <= '0;
			last_byte_q <= '0;
			ovf_q <= 1'b0;
			k_q <= '0;
			rd_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= issue;
			if (issue) begin
				k_q <= k_q + 6'd1;
			end
			if (rd_pend_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_RUN: begin
					if (pop && evt.has_bit) begin
						if (over) begin
							ovf_q <= 1'b1;
						end else begin
							bit_cnt_q <= bit_cnt_q + 9'd1;
							if (past) begin
								crc_q <= crc_nx;
								if (pos == 3'd7) begin
									// Byte complete: it goes to the store.
									cur_q <= '0;
									crc_excl_q <= crc_base_q;
									crc_base_q <= crc_nx;
									last_byte_q <= nb;
									if (idx == 6'd0) begin
										first_q <= nb;
									end
									if (idx == 6'd2) begin
										third_q <= nb;
									end
								end else begin
									cur_q <= nb;
								end
							end
						end
					end
					if (pop && evt.close) begin
						state_q <= S_CLOSE;
					end
				end
				S_CLOSE: begin
					bit_cnt_q <= '0;
					cur_q <= '0;
					crc_q <= pifr_pkg::CRC_INIT;
					crc_base_q <= pifr_pkg::CRC_INIT;
					crc_excl_q <= pifr_pkg::CRC_INIT;
					first_q <= '0;
					third_q <= '0;
					last_byte_q <= '0;
					ovf_q <= 1'b0;
					k_q <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (rd_pend_q && (k_q == cnt_e_q)) begin
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLOSE) begin
			full_e_q <= full;
			cnt_e_q <= cnt_cap[5:0];
			part_e_q <= cur_q;
			status_e_q <= stat_c;
			bc_e_q <= (byte0 == pifr_pkg::BROADCAST_ADDR);
		end
		if (issue) begin
			k_rd_q <= k_q;
		end
		if (rd_pend_q) begin
			byte_value_q <= (k_rd_q < full_e_q) ? ram_rdata : part_e_q;
			byte_index_q <= k_rd_q[4:0];
			status_q <= status_e_q;
			broadcast_q <= bc_e_q;
			last_q <= ((k_rd_q + 6'd1) == cnt_e_q);
		end
	end

	assign out_valid = out_valid_q;
	assign byte_value = byte_value_q;
	assign byte_index = byte_index_q;
	assign status = status_q;
	assign broadcast = broadcast_q;
	assign last = last_q;

	a_close_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOSE) |=> (state_q == S_EMIT))
		else $error("close step did not move on to reporting");

	a_read_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (state_q == S_EMIT))
		else $error("store read outstanding outside reporting");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (k_q <= cnt_e_q))
		else $error("report index ran past the byte count");

	a_no_store_write_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> (state_q == S_RUN))
		else $error("store written while a frame is reported");

endmodule

@@ hw/rtl/pulse_interval_frame_receiver_top.sv @@
`timescale 1ns / 1ps

// Pulse-interval frame receiver.
// Input channel (in_valid, in_stall, sample): one line sample per transaction.
// The front end detects pulse edges, classifies the gap since the previous edge
// and decides frame close within the cycle a sample is accepted, so samples go
// in at one per cycle while the queue is not full. Decoded bits and close marks
// travel through a four-entry queue to the back end, which assembles bytes, runs
// the CRC one bit per cycle while it drains the queue and keeps the frame in a
// byte store (one write, one read port). Output channel (out_valid, out_stall,
// byte_value ...): one transaction per frame byte, at most 32 per frame,
// last set on the final one. Bytes come from a registered store read, one read
// at a time. While bytes are reported the back end drains no events; the input
// stalls only when the queue is full. A stalled output holds its transaction.
// Reset restores the register defaults and an empty frame; the byte store is
// not cleared, a fill count hides stale entries. Registers sit on an APB port
// at byte addresses 4*i; the user must see that they are written only while
// the block is idle, which the block itself does not enforce.
module pulse_interval_frame_receiver_top #(
	parameter int MAX_BYTES = pifr_pkg::MAX_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pifr_pkg::ADDR_W-1:0]   paddr,
	input  logic [pifr_pkg::DATA_W-1:0]   pwdata,
	output logic [pifr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [9:0]                    sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    byte_value,
	output logic [4:0]                    byte_index,
	output logic [1:0]                    status,
	output logic                          broadcast,
	output logic                          last
);

	pifr_pkg::cfg_t cfg_q;
	logic [2:0] reg_idx;
	logic wen;

	pifr_pkg::evt_t evt_in;
	pifr_pkg::evt_t evt_out;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wen = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pifr_pkg::CFG_RESET;
		end else if (wen) begin
			unique case (reg_idx)
				pifr_pkg::REG_OWN_ID: cfg_q.own_id <= pwdata[5:0];
				pifr_pkg::REG_EDGE_THRESHOLD: cfg_q.edge_threshold <= pwdata[9:0];
				pifr_pkg::REG_GARBAGE_LIMIT: cfg_q.garbage_limit <= pwdata[15:0];
				pifr_pkg::REG_ZERO_LIMIT: cfg_q.zero_limit <= pwdata[15:0];
				pifr_pkg::REG_ONE_LIMIT: cfg_q.one_limit <= pwdata[15:0];
				pifr_pkg::REG_IDLE_TIMEOUT: cfg_q.idle_timeout <= pwdata[15:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			pifr_pkg::REG_OWN_ID: prdata = {26'd0, cfg_q.own_id};
			pifr_pkg::REG_EDGE_THRESHOLD: prdata = {22'd0, cfg_q.edge_threshold};
			pifr_pkg::REG_GARBAGE_LIMIT: prdata = {16'd0, cfg_q.garbage_limit};
			pifr_pkg::REG_ZERO_LIMIT: prdata = {16'd0, cfg_q.zero_limit};
			pifr_pkg::REG_ONE_LIMIT: prdata = {16'd0, cfg_q.one_limit};
			pifr_pkg::REG_IDLE_TIMEOUT: prdata = {16'd0, cfg_q.idle_timeout};
			default: prdata = '0;
		endcase
	end

	pifr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.q_full(q_full),
		.push(push),
		.evt(evt_in)
	);

	pifr_fifo u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(evt_in),
		.pop(pop),
		.dout(evt_out),
		.full(q_full),
		.empty(q_empty)
	);

	pifr_back #(
		.MAX_BYTES(MAX_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.evt(evt_out),
		.q_empty(q_empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.byte_value(byte_value),
		.byte_index(byte_index),
		.status(status),
		.broadcast(broadcast),
		.last(last)
	);

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import pifr_pkg::*;

	localparam int STORE_BYTES = MAX_BYTES_DEF;
	localparam int SETTLE_CYCLES = 48;

	typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_mode_t;
	typedef enum int {FLAW_NONE, FLAW_ADDRESS, FLAW_LENGTH, FLAW_CHECKSUM, FLAW_SHORT} frame_flaw_t;

	typedef struct {
		logic [7:0] value;
		logic [4:0] index;
		status_t    stat;
		logic       bcast;
		logic       last;
	} byte_report_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [9:0]        sample = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        byte_value;
	logic [4:0]        byte_index;
	logic [1:0]        status;
	logic              broadcast;
	logic              last;

	// Decoder state kept alongside the block.
	cfg_t       cfg;
	logic [9:0] line_prev;
	logic [15:0] gap_ticks;
	logic [8:0] bit_total;
	logic [7:0] frame_store [STORE_BYTES];
	bit         store_overflow;

	byte_report_t pending_reports [$];
	int           mismatches = 0;
	idle_mode_t   tx_mode = IDLE_NONE;
	idle_mode_t   rx_mode = IDLE_NONE;
	int           rx_wait = 0;
	int           hold_cycles = 0;
	logic [9:0]   last_sent = '0;

	pulse_interval_frame_receiver_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.byte_value(byte_value),
		.byte_index(byte_index),
		.status    (status),
		.broadcast (broadcast),
		.last      (last)
	);

	always #5 clk = ~clk;

	function automatic int draw_wait(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: return 0;
			IDLE_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 16)) : 0;
			default: return int'($urandom_range(0, 16));
		endcase
	endfunction

	function automatic void clear_frame();
		line_prev = '0;
		gap_ticks = IDLE_RESET;
		bit_total = '0;
		store_overflow = 1'b0;
		foreach (frame_store[i]) frame_store[i] = '0;
	endfunction

	function automatic void store_bit(input logic one);
		int slot;
		if (bit_total == BIT_COUNT_MAX) begin
			store_overflow = 1'b1;
			return;
		end
		if (bit_total >= 4) begin
			slot = (int'(bit_total) - 4) >> 3;
			if (slot >= STORE_BYTES) begin
				store_overflow = 1'b1;
				return;
			end
			frame_store[slot] = {one, frame_store[slot][7:1]};
		end
		bit_total++;
	endfunction

	function automatic logic [7:0] modbus_crc_low(input logic [7:0] data [$], input int len);
		logic [15:0] c;
		c = CRC_INIT;
		for (int i = 0; i < len && i < data.size(); i++) begin
			c ^= {8'h00, data[i]};
			for (int j = 0; j < 8; j++)
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c[7:0];
	endfunction

	function automatic status_t frame_verdict();
		int full;
		logic [7:0] bytes [$];
		full = (bit_total >= 4) ? ((int'(bit_total) - 4) >> 3) : 0;
		if (frame_store[0] != {2'b00, cfg.own_id} && frame_store[0] != BROADCAST_ADDR)
			return ST_NOT_ADDR;
		if (store_overflow || full > STORE_BYTES || full != int'(frame_store[2]) + 3)
			return ST_LENGTH;
		foreach (frame_store[i]) bytes.push_back(frame_store[i]);
		if (modbus_crc_low(bytes, full - 1) != frame_store[full - 1])
			return ST_CRC;
		return ST_OK;
	endfunction

	// Advances the decoder by one accepted sample and queues the byte reports
	// of a frame that closes on it.
	function automatic void absorb_sample(input logic [9:0] s);
		int count;
		status_t verdict;
		byte_report_t r;
		if (int'(s) - int'(line_prev) > int'(cfg.edge_threshold)) begin
			if (gap_ticks >= cfg.garbage_limit && gap_ticks < cfg.one_limit)
				store_bit(gap_ticks >= cfg.zero_limit);
			gap_ticks = '0;
		end
		line_prev = s;
		if (gap_ticks != IDLE_SAT) gap_ticks++;
		if (!(gap_ticks > cfg.idle_timeout && bit_total != 0)) return;
		count = (bit_total >= 5) ? (((int'(bit_total) - 5) >> 3) + 1) : 1;
		if (count > STORE_BYTES) count = STORE_BYTES;
		verdict = frame_verdict();
		for (int k = 0; k < count; k++) begin
			r.value = frame_store[k];
			r.index = 5'(k);
			r.stat = verdict;
			r.bcast = (frame_store[0] == BROADCAST_ADDR);
			r.last = (k + 1 == count);
			pending_reports.push_back(r);
		end
		clear_frame();
	endfunction

	task automatic send_sample(input logic [9:0] s);
		int w;
		w = draw_wait(tx_mode);
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		absorb_sample(s);
		last_sent = s;
	endtask

	function automatic logic [9:0] low_level();
		return 10'($urandom_range(0, int'(cfg.edge_threshold)));
	endfunction

	function automatic logic [9:0] high_level();
		return 10'($urandom_range(int'(last_sent) + int'(cfg.edge_threshold) + 1, 1023));
	endfunction

	// A gap of n puts n - 1 quiet samples before the pulse edge.
	task automatic send_pulse(input int gap);
		repeat (gap - 1) send_sample(low_level());
		send_sample(high_level());
	endtask

	task automatic send_bit(input logic b);
		if ($urandom_range(0, 7) == 0)
			send_pulse($urandom_range(2, int'(cfg.garbage_limit) - 1));
		if (b)
			send_pulse($urandom_range(int'(cfg.zero_limit), int'(cfg.one_limit) - 1));
		else
			send_pulse($urandom_range(int'(cfg.garbage_limit), int'(cfg.zero_limit) - 1));
	endtask

	task automatic send_frame(input int nbytes, input frame_flaw_t flaw);
		logic [7:0] data [$];
		int keep;
		int tail;
		for (int i = 0; i < nbytes; i++) data.push_back(8'($urandom_range(0, 255)));
		data[0] = $urandom_range(0, 1) ? BROADCAST_ADDR : {2'b00, cfg.own_id};
		data[2] = 8'(nbytes - 3);
		data[nbytes - 1] = modbus_crc_low(data, nbytes - 1);
		keep = nbytes;
		tail = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 7)) : 0;
		case (flaw)
			FLAW_ADDRESS: data[0] = 8'($urandom_range(64, 254));
			FLAW_LENGTH: data[2] ^= 8'($urandom_range(1, 255));
			FLAW_CHECKSUM: data[nbytes - 1] ^= 8'($urandom_range(1, 255));
			FLAW_SHORT: keep = $urandom_range(0, 2);
			default: begin end
		endcase
		send_pulse(int'(cfg.one_limit) + $urandom_range(0, 3));
		repeat (4) send_bit($urandom_range(0, 1));
		for (int i = 0; i < keep; i++)
			for (int j = 0; j < 8; j++) send_bit(data[i][j]);
		repeat (tail) send_bit($urandom_range(0, 1));
		repeat (int'(cfg.idle_timeout) + $urandom_range(1, 4)) send_sample(low_level());
	endtask

	task automatic send_line_noise(input int n);
		repeat (n) send_sample(10'($urandom_range(0, 1023)));
		repeat (int'(cfg.idle_timeout) + 2) send_sample(low_level());
	endtask

	task automatic drain_reports();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Back-to-back APB writes; psel drops only after the last one.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_OWN_ID: cfg.own_id = value[5:0];
			REG_EDGE_THRESHOLD: cfg.edge_threshold = value[9:0];
			REG_GARBAGE_LIMIT: cfg.garbage_limit = value[15:0];
			REG_ZERO_LIMIT: cfg.zero_limit = value[15:0];
			REG_ONE_LIMIT: cfg.one_limit = value[15:0];
			REG_IDLE_TIMEOUT: cfg.idle_timeout = value[15:0];
			default: begin end
		endcase
	endtask

	task automatic set_config(input logic [31:0] own, input logic [31:0] thr,
			input logic [31:0] garb, input logic [31:0] zero, input logic [31:0] one,
			input logic [31:0] tmo);
		drain_reports();
		write_reg(REG_OWN_ID, own);
		write_reg(REG_EDGE_THRESHOLD, thr);
		write_reg(REG_GARBAGE_LIMIT, garb);
		write_reg(REG_ZERO_LIMIT, zero);
		write_reg(REG_ONE_LIMIT, one);
		write_reg(REG_IDLE_TIMEOUT, tmo);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic pick_frame_config();
		int g;
		int z;
		int o;
		g = $urandom_range(3, 5);
		z = g + $urandom_range(1, 4);
		o = z + $urandom_range(1, 4);
		set_config($urandom_range(0, 63), $urandom_range(20, 400), g, z, o,
			o + $urandom_range(0, 8));
	endtask

	function automatic frame_flaw_t pick_flaw();
		case ($urandom_range(0, 9))
			6: return FLAW_ADDRESS;
			7: return FLAW_LENGTH;
			8: return FLAW_CHECKSUM;
			9: return FLAW_SHORT;
			default: return FLAW_NONE;
		endcase
	endfunction

	task automatic test_directed_edges();
		logic [9:0] opening [$] = '{10'd1023, 10'd943, 10'd1023};
		logic [9:0] boundary [$] = '{10'd0, 10'd81, 10'd0, 10'd81, 10'd1, 10'd81, 10'd0,
			10'd0, 10'd1023, 10'd0, 10'd0, 10'd162, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
			10'd81, 10'd200, 10'd0};
		// Reset registers first: a rise of exactly the threshold is not an edge.
		foreach (opening[i]) send_sample(opening[i]);
		// Narrow limits put every gap class and the close boundary within reach.
		set_config(0, 80, 2, 3, 4, 3);
		foreach (boundary[i]) send_sample(boundary[i]);
	endtask

	task automatic test_random_frames();
		for (int phase = 0; phase < 4; phase++) begin
			pick_frame_config();
			tx_mode = idle_mode_t'(phase % 3);
			rx_mode = idle_mode_t'((phase * 2) % 3);
			repeat (3) begin
				send_frame($urandom_range(3, 8), pick_flaw());
				if ($urandom_range(0, 2) == 0) send_line_noise($urandom_range(3, 12));
			end
		end
	endtask

	task automatic test_backpressure();
		pick_frame_config();
		tx_mode = IDLE_NONE;
		rx_mode = IDLE_SOME;
		// The output stays blocked while the next frame is offered, so the event
		// queue fills and the input has to stall.
		hold_cycles <= 800;
		send_frame(4, FLAW_NONE);
		send_frame(5, FLAW_NONE);
		drain_reports();
		send_frame($urandom_range(3, 6), FLAW_NONE);
	endtask

	task automatic test_store_overflow();
		set_config($urandom_range(0, 63), 100, 3, 5, 8, 10);
		tx_mode = IDLE_SOME;
		rx_mode = IDLE_SOME;
		send_frame(32, FLAW_NONE);
		send_frame(34, FLAW_NONE);
	endtask

	task automatic test_register_extremes();
		// Upper bits beyond the own-ID and edge-threshold widths are written too and must be dropped.
		set_config(32'hFFFF_FFFF, 0, 0, 1, 2, 1);
		tx_mode = IDLE_FULL;
		rx_mode = IDLE_FULL;
		send_sample(10'd0);
		send_sample(10'd1023);
		repeat (40) send_sample(10'($urandom_range(0, 1023)));
		set_config(0, 32'hFFFF_FFFF, 65535, 65535, 65535, 65535);
		send_sample(10'd1023);
		repeat (30) send_sample(10'($urandom_range(0, 1023)));
	endtask

	task automatic test_idle_saturation();
		set_config(0, 80, 0, 0, 65535, 65535);
		tx_mode = IDLE_NONE;
		rx_mode = IDLE_SOME;
		repeat (14) send_pulse(2);
		// The gap counter pins at its maximum and the frame never times out.
		repeat (65540) send_sample(low_level());
		send_pulse(2);
		set_config(0, 80, 0, 0, 65535, 1);
		repeat (3) send_sample(low_level());
	endtask

	always @(posedge clk) begin : check_reports
		byte_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: value %0d index %0d status %0d",
						byte_value, byte_index, status);
			end else begin
				want = pending_reports.pop_front();
				if (byte_value !== want.value || byte_index !== want.index ||
						status !== want.stat || broadcast !== want.bcast ||
						last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"byte report: expected value %0d index %0d status %0d ",
							"bcast %0b last %0b, got %0d %0d %0d %0b %0b"},
							want.value, want.index, want.stat, want.bcast, want.last,
							byte_value, byte_index, status, broadcast, last);
				end
			end
		end
	end

	always @(posedge clk) begin : drive_stall
		if (out_valid && !out_stall)
			rx_wait = draw_wait(rx_mode);
		else if (rx_wait > 0)
			rx_wait--;
		out_stall <= (hold_cycles > 0) || (rx_wait > 0);
	end

	always @(posedge clk)
		if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		cfg = CFG_RESET;
		clear_frame();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_random_frames();
		test_backpressure();
		test_store_overflow();
		test_register_extremes();
		test_idle_saturation();
		drain_reports();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
